FILE: hw/rtl/hca_pkg.sv
// Package for the heap chunk allocator: result codes, strategy codes,
// configuration register indexes, map cell marks and the sequencer state type.
// No dependencies.
package hca_pkg;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_NEXT  = 2'd1,
    FIT_BEST  = 2'd2,
    FIT_WORST = 2'd3
  } strategy_t;

  typedef enum logic [1:0] {
    CFG_STRATEGY  = 2'd0,
    CFG_HEAP_BASE = 2'd1,
    CFG_CELLS     = 2'd2
  } cfg_index_t;

  localparam logic [3:0]  MARK_FREE    = 4'd0;
  localparam logic [3:0]  MARK_CONT    = 4'd15;
  localparam logic [10:0] CELLS_RESET  = 11'd1024;

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_SCAN   = 6'b000100,
    S_MARK   = 6'b001000,
    S_RESULT = 6'b010000,
    S_SPARE  = 6'b100000
  } state_t;

endpackage

FILE: hw/rtl/heap_chunk_allocator.sv
// Heap chunk allocator: cell map memory, scan/mark sequencer, result register.
// Depends on hca_pkg.
//
// Channel   Handshake               Payload
// req       req_valid / req_stall   request_size, owner_id
// rsp       rsp_valid / rsp_stall   status, chunk_address
// cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// After reset a clearing pass writes every map cell to free, during which no
// request is taken (configuration writes are).
// A request runs a scan of one map cell per cycle through the single map read
// port, a second scan from cell 0 when a next fit search wraps, then a mark
// pass that writes request_size cells through the write port. A bad request
// skips the scan; a full heap answers after the whole scan.
// A result waits in the output register while rsp_stall is high.
module heap_chunk_allocator #(
  parameter int HEAP_CELLS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [10:0] request_size,
  input  logic [3:0]  owner_id,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [1:0]  status,
  output logic [15:0] chunk_address,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IW = (HEAP_CELLS > 1) ? $clog2(HEAP_CELLS) : 1;
  localparam int CW = $clog2(HEAP_CELLS + 1);
  localparam int LW = (CW > 11) ? CW : 11;

  // configuration
  logic [1:0]  strategy;
  logic [15:0] heap_base;
  logic [10:0] cells_in_use;

  // sequencer
  hca_pkg::state_t state, state_next;
  logic [CW-1:0] ptr, ptr_next;
  logic [CW-1:0] run, run_next;
  logic [CW-1:0] chosen, chosen_next;
  logic [IW-1:0] start, start_next;
  logic [IW-1:0] head, head_next;
  logic [IW-1:0] next_fit, next_fit_next;
  logic [10:0]   size_q, size_next;
  logic [3:0]    owner_q, owner_next;
  logic [1:0]    result, result_next;
  logic          found, found_next;
  logic          second, second_next;
  logic          from_nz, from_nz_next;
  logic          rsp_load;

  // map memory
  logic [3:0]    cell_mem [HEAP_CELLS];
  logic [3:0]    rd_data;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [3:0]    wr_data;

  // derived
  logic [CW-1:0] n_cells;
  logic [IW-1:0] from_idx;
  logic          bad_req;
  logic          first_mode;
  logic          at_end;
  logic          cell_free;
  logic [CW-1:0] run_inc;
  logic [CW-1:0] ptr_inc;
  logic          run_fits;
  logic          take;
  logic [IW-1:0] hit_head;
  logic [IW-1:0] end_head;

  assign n_cells = (32'(cells_in_use) < 32'(HEAP_CELLS)) ? CW'(cells_in_use)
                                                          : CW'(HEAP_CELLS);
  assign from_idx = (CW'(next_fit) < n_cells) ? next_fit : '0;
  assign bad_req  = (request_size == 11'd0) || (owner_id == hca_pkg::MARK_FREE) ||
                    (owner_id == hca_pkg::MARK_CONT) ||
                    (LW'(request_size) > LW'(n_cells));
  assign first_mode = (strategy == hca_pkg::FIT_FIRST) ||
                      (strategy == hca_pkg::FIT_NEXT);

  assign at_end    = (ptr == n_cells);
  assign cell_free = !at_end && (rd_data == hca_pkg::MARK_FREE);
  assign run_inc   = run + CW'(1);
  assign ptr_inc   = ptr + CW'(1);
  assign run_fits  = (run != '0) && (LW'(run) >= LW'(size_q));
  assign take      = run_fits && (!found ||
                     ((strategy == hca_pkg::FIT_BEST) && (run < chosen)) ||
                     ((strategy == hca_pkg::FIT_WORST) && (run > chosen)));
  assign hit_head  = (run == '0) ? ptr[IW-1:0] : start;
  assign end_head  = take ? start : head;

  assign req_stall = (state != hca_pkg::S_IDLE);
  assign cfg_ready = (state == hca_pkg::S_IDLE) || (state == hca_pkg::S_CLEAR);
  assign rsp_load  = (state == hca_pkg::S_RESULT) && (!rsp_valid || !rsp_stall);

  // read the cell the sequencer moves to next
  assign rd_addr = ptr_next[IW-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr[IW-1:0];
    wr_data = hca_pkg::MARK_FREE;
    if (state == hca_pkg::S_CLEAR) begin
      wr_en = 1'b1;
    end else if (state == hca_pkg::S_MARK) begin
      wr_en   = 1'b1;
      wr_data = (ptr[IW-1:0] == head) ? owner_q : hca_pkg::MARK_CONT;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cell_mem[wr_addr] <= wr_data;
    end
    rd_data <= cell_mem[rd_addr];
  end

  always_comb begin
    state_next    = state;
    ptr_next      = ptr;
    run_next      = run;
    chosen_next   = chosen;
    start_next    = start;
    head_next     = head;
    next_fit_next = next_fit;
    size_next     = size_q;
    owner_next    = owner_q;
    result_next   = result;
    found_next    = found;
    second_next   = second;
    from_nz_next  = from_nz;
    unique case (state)
      hca_pkg::S_CLEAR: begin
        ptr_next = ptr_inc;
        if (ptr[IW-1:0] == IW'(HEAP_CELLS - 1)) begin
          ptr_next   = '0;
          state_next = hca_pkg::S_IDLE;
        end
      end
      hca_pkg::S_IDLE: begin
        if (req_valid) begin
          size_next  = request_size;
          owner_next = owner_id;
          if (bad_req) begin
            result_next = hca_pkg::ST_BAD;
            state_next  = hca_pkg::S_RESULT;
          end else begin
            ptr_next     = CW'(from_idx);
            run_next     = '0;
            found_next   = 1'b0;
            second_next  = 1'b0;
            from_nz_next = (from_idx != '0);
            state_next   = hca_pkg::S_SCAN;
          end
        end
      end
      hca_pkg::S_SCAN: begin
        if (cell_free) begin
          if (run == '0) begin
            start_next = ptr[IW-1:0];
          end
          run_next = run_inc;
          ptr_next = ptr_inc;
          if (first_mode && (LW'(run_inc) == LW'(size_q))) begin
            head_next  = hit_head;
            ptr_next   = CW'(hit_head);
            run_next   = CW'(size_q);
            state_next = hca_pkg::S_MARK;
          end
        end else begin
          run_next = '0;
          if (take) begin
            found_next  = 1'b1;
            chosen_next = run;
            head_next   = start;
          end
          if (!at_end) begin
            ptr_next = ptr_inc;
          end else if (found || take) begin
            head_next  = end_head;
            ptr_next   = CW'(end_head);
            run_next   = CW'(size_q);
            state_next = hca_pkg::S_MARK;
          end else if ((strategy == hca_pkg::FIT_NEXT) && !second && from_nz) begin
            // wrap: rescan from the heap start
            second_next = 1'b1;
            ptr_next    = '0;
          end else begin
            result_next = hca_pkg::ST_FULL;
            state_next  = hca_pkg::S_RESULT;
          end
        end
      end
      hca_pkg::S_MARK: begin
        ptr_next = ptr_inc;
        run_next = run - CW'(1);
        if (run == CW'(1)) begin
          result_next = hca_pkg::ST_OK;
          state_next  = hca_pkg::S_RESULT;
          if (strategy == hca_pkg::FIT_NEXT) begin
            next_fit_next = (ptr_inc >= n_cells) ? '0 : ptr_inc[IW-1:0];
          end
        end
      end
      hca_pkg::S_RESULT: begin
        if (rsp_load) begin
          state_next = hca_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = hca_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hca_pkg::S_CLEAR;
      ptr       <= '0;
      run       <= '0;
      found     <= 1'b0;
      second    <= 1'b0;
      from_nz   <= 1'b0;
      next_fit  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state    <= state_next;
      ptr      <= ptr_next;
      run      <= run_next;
      found    <= found_next;
      second   <= second_next;
      from_nz  <= from_nz_next;
      next_fit <= next_fit_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    chosen  <= chosen_next;
    start   <= start_next;
    head    <= head_next;
    size_q  <= size_next;
    owner_q <= owner_next;
    result  <= result_next;
    if (rsp_load) begin
      status        <= result;
      chunk_address <= (result == hca_pkg::ST_OK) ? (heap_base + 16'(head)) : 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strategy     <= hca_pkg::FIT_FIRST;
      heap_base    <= '0;
      cells_in_use <= hca_pkg::CELLS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        hca_pkg::CFG_STRATEGY:  strategy     <= cfg_data[1:0];
        hca_pkg::CFG_HEAP_BASE: heap_base    <= cfg_data;
        hca_pkg::CFG_CELLS:     cells_in_use <= cfg_data[10:0];
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fail_no_addr: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (status != hca_pkg::ST_OK)) |-> (chunk_address == 16'd0))
    else $error("failed request carries a chunk address");

  a_mark_in_heap: assert property (@(posedge clk) disable iff (rst)
    (state == hca_pkg::S_MARK) |-> (ptr < n_cells))
    else $error("mark pass writes beyond the usable cells");

  a_scan_in_heap: assert property (@(posedge clk) disable iff (rst)
    (state == hca_pkg::S_SCAN) |-> (ptr <= n_cells))
    else $error("scan pointer runs past the end of the heap");

  a_mark_len: assert property (@(posedge clk) disable iff (rst)
    ((state == hca_pkg::S_SCAN) && (state_next == hca_pkg::S_MARK)) |=>
    ((LW'(run) == LW'(size_q)) && (ptr[IW-1:0] == head)))
    else $error("mark pass starts with a wrong length or head");
`endif

endmodule
